### rtl/gdd_pkg.sv
package gdd_pkg;

   // Widths of the datapath.
   localparam int unsigned YEAR_W = 14;
   localparam int unsigned YB_W   = 15;
   localparam int unsigned MUL_AW = 15;
   localparam int unsigned MUL_BW = 11;
   localparam int unsigned PROD_W = 23;
   localparam int unsigned QUO_W  = 8;
   localparam int unsigned ACC_W  = 25;
   localparam int unsigned DIFF_W = 23;

   // Year bias: the day count starts 400 years before year 1.
   localparam logic [YB_W-1:0] YEAR_BIAS = 15'd399;

   // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for every x below 4196.
   localparam logic [MUL_BW-1:0] RECIP_25      = 11'd1311;
   localparam int unsigned       RECIP_SHIFT   = 15;
   localparam logic [MUL_BW-1:0] YEARS_CENTURY = 11'd100;
   localparam logic [MUL_BW-1:0] DAYS_PER_YEAR = 11'd365;

   localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
   localparam logic [3:0] MONTH_FEB    = 4'd2;
   localparam logic [3:0] MONTH_DEC    = 4'd12;

   localparam logic signed [ACC_W-1:0] DD_MAX = 25'sd4194303;
   localparam logic signed [ACC_W-1:0] DD_MIN = -25'sd4194304;

   typedef struct packed {
      logic [YEAR_W-1:0] first_year;
      logic [3:0]        first_month;
      logic [4:0]        first_day;
      logic [YEAR_W-1:0] second_year;
      logic [3:0]        second_month;
      logic [4:0]        second_day;
      logic              include_end_day;
   } req_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] day_difference;
      logic                     date_invalid;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_Y,
      ST_MUL_C,
      ST_MUL_B,
      ST_MUL_365,
      ST_ADD_P,
      ST_ADD_Q,
      ST_ADD_R,
      ST_ADD_D,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Length of a month in a common year; zero for codes that are not months.
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the months before month m of a common year.
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

### rtl/gregorian_day_difference_top.sv
// Gregorian day difference. Each request carries two dates (year, month,
// day) and an include-end-day flag; the response gives the signed number of
// days from the first date to the second, plus one when the flag is set, so
// a second date earlier than the first yields a negative count. Each date is
// turned into a day count from an epoch 400 years before year 1 (365 days a
// year plus the 4/100/400 leap corrections plus the day of year), and the
// two counts are subtracted. A date with a month outside 1 to 12, a day of
// zero or a day past the end of its month sets date_invalid and forces the
// difference to zero. Years are used as given, year 0 counting as a leap
// year; a difference beyond the 23-bit signed range saturates. One request
// is processed at a time by a single shared multiplier and a single shared
// accumulator under a small sequencer: eight steps per date, one step for
// the end-day flag and one to load the output register; that last step
// waits while the register holds a response not yet taken. The output
// register lets a new request enter while the previous response still waits.
module gregorian_day_difference_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gdd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output gdd_pkg::rsp_type rsp_data
);

   // Sequencer state and the captured request.
   gdd_pkg::state_type state_ff, state_in;
   gdd_pkg::req_type   req_ff;
   logic               sel_ff, sel_in;

   // Shared multiplier and its result register.
   logic [gdd_pkg::MUL_AW-1:0] mul_a;
   logic [gdd_pkg::MUL_BW-1:0] mul_b;
   logic [gdd_pkg::MUL_AW+gdd_pkg::MUL_BW-1:0] mul_full;
   logic [gdd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                       prod_en;

   // Quotients and leap flag of the date being worked on.
   logic [gdd_pkg::QUO_W-1:0] qy_ff, q100b_ff;
   logic                      leap_ff, leap_in;

   // Shared accumulator.
   logic signed [gdd_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [gdd_pkg::PROD_W-1:0]       term;
   logic                             acc_en, term_neg;

   logic bad_ff, bad_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   gdd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_load;

   // Fields of the date currently selected.
   logic [gdd_pkg::YEAR_W-1:0] y_cur;
   logic [3:0]                 m_cur;
   logic [4:0]                 d_cur;
   logic [gdd_pkg::YB_W-1:0]   yb_cur;
   logic [4:0]                 len_cur;
   logic                       date_ok;
   logic                       req_fire;
   logic signed [gdd_pkg::ACC_W-1:0] sat_value;

   assign req_ready = (state_ff == gdd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign y_cur  = sel_ff ? req_ff.second_year  : req_ff.first_year;
   assign m_cur  = sel_ff ? req_ff.second_month : req_ff.first_month;
   assign d_cur  = sel_ff ? req_ff.second_day   : req_ff.first_day;
   assign yb_cur = gdd_pkg::YB_W'(y_cur) + gdd_pkg::YEAR_BIAS;

   // The month length uses the leap flag found earlier in this date's pass.
   always_comb begin
      len_cur = gdd_pkg::month_len(m_cur);
      if (m_cur == gdd_pkg::MONTH_FEB && leap_ff) begin
         len_cur = gdd_pkg::FEB_LEAP_LEN;
      end
      date_ok = (m_cur != 4'd0) && (m_cur <= gdd_pkg::MONTH_DEC) &&
                (d_cur != 5'd0) && (d_cur <= len_cur);
   end

   assign mul_full = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = gdd_pkg::ST_MUL_Y;
            end
         end
         gdd_pkg::ST_MUL_Y:   state_in = gdd_pkg::ST_MUL_C;
         gdd_pkg::ST_MUL_C:   state_in = gdd_pkg::ST_MUL_B;
         gdd_pkg::ST_MUL_B:   state_in = gdd_pkg::ST_MUL_365;
         gdd_pkg::ST_MUL_365: state_in = gdd_pkg::ST_ADD_P;
         gdd_pkg::ST_ADD_P:   state_in = gdd_pkg::ST_ADD_Q;
         gdd_pkg::ST_ADD_Q:   state_in = gdd_pkg::ST_ADD_R;
         gdd_pkg::ST_ADD_R:   state_in = gdd_pkg::ST_ADD_D;
         gdd_pkg::ST_ADD_D: begin
            state_in = sel_ff ? gdd_pkg::ST_FINISH : gdd_pkg::ST_MUL_Y;
         end
         gdd_pkg::ST_FINISH:  state_in = gdd_pkg::ST_DONE;
         gdd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = gdd_pkg::ST_IDLE;
            end
         end
         default:             state_in = gdd_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls for each step.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      prod_en  = 1'b0;
      term     = '0;
      acc_en   = 1'b0;
      term_neg = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         gdd_pkg::ST_MUL_Y: begin
            // floor(y / 100) = floor((y / 4) / 25)
            mul_a   = gdd_pkg::MUL_AW'(y_cur[gdd_pkg::YEAR_W-1:2]);
            mul_b   = gdd_pkg::RECIP_25;
            prod_en = 1'b1;
         end
         gdd_pkg::ST_MUL_C: begin
            // Multiply the century back to test whether y divides by 100.
            mul_a   = gdd_pkg::MUL_AW'(prod_ff[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SHIFT]);
            mul_b   = gdd_pkg::YEARS_CENTURY;
            prod_en = 1'b1;
         end
         gdd_pkg::ST_MUL_B: begin
            mul_a   = gdd_pkg::MUL_AW'(yb_cur[gdd_pkg::YB_W-1:2]);
            mul_b   = gdd_pkg::RECIP_25;
            prod_en = 1'b1;
         end
         gdd_pkg::ST_MUL_365: begin
            mul_a   = yb_cur;
            mul_b   = gdd_pkg::DAYS_PER_YEAR;
            prod_en = 1'b1;
            term    = gdd_pkg::PROD_W'(yb_cur[gdd_pkg::YB_W-1:2]);
            acc_en  = 1'b1;
         end
         gdd_pkg::ST_ADD_P: begin
            term   = prod_ff;
            acc_en = 1'b1;
         end
         gdd_pkg::ST_ADD_Q: begin
            term   = gdd_pkg::PROD_W'(q100b_ff);
            acc_en = 1'b1;
         end
         gdd_pkg::ST_ADD_R: begin
            term   = gdd_pkg::PROD_W'(q100b_ff[gdd_pkg::QUO_W-1:2]);
            acc_en = 1'b1;
         end
         gdd_pkg::ST_ADD_D: begin
            term   = gdd_pkg::PROD_W'(gdd_pkg::days_before(m_cur)) +
                     gdd_pkg::PROD_W'((m_cur > gdd_pkg::MONTH_FEB) && leap_ff) +
                     gdd_pkg::PROD_W'(d_cur);
            acc_en = 1'b1;
         end
         gdd_pkg::ST_FINISH: begin
            term   = gdd_pkg::PROD_W'(req_ff.include_end_day);
            acc_en = 1'b1;
         end
         gdd_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
      // The first date is subtracted, the second added; the century term
      // has the opposite sign of its date.
      if (state_ff != gdd_pkg::ST_FINISH) begin
         term_neg = (state_ff == gdd_pkg::ST_ADD_Q) ^ !sel_ff;
      end
   end

   // Register next values.
   always_comb begin
      prod_in = prod_en ? mul_full[gdd_pkg::PROD_W-1:0] : prod_ff;

      // Leap: divisible by 4, and not by 100 unless also by 400.
      leap_in = leap_ff;
      if (state_ff == gdd_pkg::ST_MUL_B) begin
         leap_in = (y_cur[1:0] == 2'b00) &&
                   ((prod_ff != gdd_pkg::PROD_W'(y_cur)) || (qy_ff[1:0] == 2'b00));
      end

      acc_in = acc_ff;
      if (req_fire) begin
         acc_in = '0;
      end else if (acc_en) begin
         acc_in = term_neg ? acc_ff - $signed({2'b00, term})
                           : acc_ff + $signed({2'b00, term});
      end

      bad_in = bad_ff;
      if (req_fire) begin
         bad_in = 1'b0;
      end else if (state_ff == gdd_pkg::ST_ADD_D) begin
         bad_in = bad_ff || !date_ok;
      end

      sel_in = sel_ff;
      if (req_fire) begin
         sel_in = 1'b0;
      end else if (state_ff == gdd_pkg::ST_ADD_D) begin
         sel_in = 1'b1;
      end

      priority if (acc_ff > gdd_pkg::DD_MAX) begin
         sat_value = gdd_pkg::DD_MAX;
      end else if (acc_ff < gdd_pkg::DD_MIN) begin
         sat_value = gdd_pkg::DD_MIN;
      end else begin
         sat_value = acc_ff;
      end

      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.day_difference = bad_ff ? '0 : sat_value[gdd_pkg::DIFF_W-1:0];
         rsp_data_in.date_invalid   = bad_ff;
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      prod_ff <= prod_in;
      if (state_ff == gdd_pkg::ST_MUL_C) begin
         qy_ff <= prod_ff[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SHIFT];
      end
      if (state_ff == gdd_pkg::ST_MUL_365) begin
         q100b_ff <= prod_ff[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SHIFT];
      end
      leap_ff     <= leap_in;
      acc_ff      <= acc_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // An accepted request always starts the first date's pass.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == gdd_pkg::ST_MUL_Y) && !sel_ff)
      else $error("request accepted but sequencer did not start");

   // An invalid date never reports a nonzero difference.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.date_invalid) |-> (rsp_data.day_difference == '0))
      else $error("invalid date with nonzero difference");

   // A new response only follows the final sequencer step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == gdd_pkg::ST_DONE))
      else $error("response raised outside the final step");
`endif

endmodule
